// ===== hdl/dwms_pkg.sv =====
// ----------------------------------------------------------------------------
// Distinct-window max sum: shared definitions
// Sizes, item word layout and small helpers used by the front, the queue and
// the execution back end.
// ----------------------------------------------------------------------------
package dwms_pkg;

   // Largest value that enters the window; the mark table and the window
   // ring both hold one entry per possible value.
   localparam int MAX_VALUE = 1023;
   localparam int DEPTH     = MAX_VALUE + 1;
   localparam int PTR_W     = $clog2(DEPTH);

   // Fixed field widths of the ports
   localparam int VAL_W   = 10;
   localparam int SCORE_W = 19;
   localparam int LEN_W   = 10;

   // Internal sums are wide enough for the largest possible window sum
   localparam longint MAX_SUM  = longint'(MAX_VALUE) * (longint'(MAX_VALUE) + 1) / 2;
   localparam int     SUM_BITS = $clog2(MAX_SUM + 1);
   localparam int     SUM_W    = (SUM_BITS > SCORE_W) ? SUM_BITS : SCORE_W;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [VAL_W-1:0]   val_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [PTR_W-1:0]   cnt_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [SCORE_W-1:0] score_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [QPTR_W-1:0]  qptr_type;
   typedef logic [QCNT_W-1:0]  qcnt_type;

   // One classified input word
   typedef struct packed {
      val_type value;
      logic    first;
      logic    in_range;
   } item_type;

   function automatic logic value_in_range(val_type v);
      return (v != '0) && (int'(v) <= MAX_VALUE);
   endfunction

   function automatic ptr_type value_index(val_type v);
      return ptr_type'(v);
   endfunction

   function automatic ptr_type ptr_inc(ptr_type p);
      if (p == ptr_type'(DEPTH - 1)) begin
         return '0;
      end
      return p + ptr_type'(1);
   endfunction

endpackage

// ===== hdl/dwms_front.sv =====
// ----------------------------------------------------------------------------
// Distinct-window max sum: front stage
// Accepts request words, classifies the value range and holds the word in a
// register until the queue takes it.
// ----------------------------------------------------------------------------
module dwms_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               hold,
   input  logic               req_valid,
   output logic               req_ready,
   input  dwms_pkg::val_type  req_value,
   input  logic               req_first,
   output logic               push_valid,
   output dwms_pkg::item_type push_item,
   input  logic               push_ready
);

   logic               stage_valid_ff;
   logic               stage_valid_in;
   dwms_pkg::item_type stage_item_ff;
   dwms_pkg::item_type stage_item_in;
   logic               take;

   assign req_ready  = !hold && (!stage_valid_ff || push_ready);
   assign take       = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (stage_valid_ff && push_ready) begin
         stage_valid_in = 1'b0;
      end
      if (take) begin
         stage_valid_in         = 1'b1;
         stage_item_in.value    = req_value;
         stage_item_in.first    = req_first;
         stage_item_in.in_range = dwms_pkg::value_in_range(req_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

endmodule

// ===== hdl/dwms_queue.sv =====
// ----------------------------------------------------------------------------
// Distinct-window max sum: decoupling queue
// Small register FIFO of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module dwms_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  dwms_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output dwms_pkg::item_type pop_item,
   input  logic               pop
);

   dwms_pkg::item_type  entry_ff [dwms_pkg::QUEUE_DEPTH];
   dwms_pkg::qptr_type  wr_ptr_ff;
   dwms_pkg::qptr_type  wr_ptr_in;
   dwms_pkg::qptr_type  rd_ptr_ff;
   dwms_pkg::qptr_type  rd_ptr_in;
   dwms_pkg::qcnt_type  fill_ff;
   dwms_pkg::qcnt_type  fill_in;
   logic                do_push;
   logic                do_pop;

   function automatic dwms_pkg::qptr_type qptr_inc(dwms_pkg::qptr_type p);
      if (p == dwms_pkg::qptr_type'(dwms_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + dwms_pkg::qptr_type'(1);
   endfunction

   assign push_ready = (fill_ff != dwms_pkg::qcnt_type'(dwms_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? qptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? qptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + dwms_pkg::qcnt_type'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - dwms_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/dwms_back.sv =====
// ----------------------------------------------------------------------------
// Distinct-window max sum: execution back end
// Owns the mark table and the window ring, runs the clear pass, the drain on
// a new array, the eviction loop and the append, and drives the result word.
// ----------------------------------------------------------------------------
module dwms_back (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clearing,
   input  logic                 q_valid,
   input  dwms_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dwms_pkg::score_type  rsp_best_score,
   output dwms_pkg::score_type  rsp_window_sum,
   output dwms_pkg::len_type    rsp_window_length
);

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_DRAIN_RD = 8'b0000_0100,
      ST_DRAIN_WR = 8'b0000_1000,
      ST_CHECK    = 8'b0001_0000,
      ST_EVICT    = 8'b0010_0000,
      ST_APPEND   = 8'b0100_0000,
      ST_RESULT   = 8'b1000_0000
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   dwms_pkg::item_type  cur_ff;
   dwms_pkg::item_type  cur_in;
   dwms_pkg::ptr_type   clr_ff;
   dwms_pkg::ptr_type   clr_in;
   dwms_pkg::ptr_type   head_ff;
   dwms_pkg::ptr_type   head_in;
   dwms_pkg::ptr_type   tail_ff;
   dwms_pkg::ptr_type   tail_in;
   dwms_pkg::cnt_type   count_ff;
   dwms_pkg::cnt_type   count_in;
   dwms_pkg::sum_type   sum_ff;
   dwms_pkg::sum_type   sum_in;
   dwms_pkg::sum_type   best_ff;
   dwms_pkg::sum_type   best_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   dwms_pkg::score_type best_out_ff;
   dwms_pkg::score_type best_out_in;
   dwms_pkg::score_type sum_out_ff;
   dwms_pkg::score_type sum_out_in;
   dwms_pkg::len_type   len_out_ff;
   dwms_pkg::len_type   len_out_in;

   // Mark table: one presence bit per value
   logic                mark_mem [dwms_pkg::DEPTH];
   logic                mark_we;
   dwms_pkg::ptr_type   mark_wa;
   logic                mark_wd;
   logic                mark_re;
   dwms_pkg::ptr_type   mark_ra;
   logic                mark_rd_ff;

   // Window ring: values in arrival order
   dwms_pkg::val_type   ring_mem [dwms_pkg::DEPTH];
   logic                ring_we;
   dwms_pkg::ptr_type   ring_wa;
   dwms_pkg::val_type   ring_wd;
   logic                ring_re;
   dwms_pkg::ptr_type   ring_ra;
   dwms_pkg::val_type   ring_rd_ff;

   logic                out_free;
   dwms_pkg::sum_type   ev_val;
   dwms_pkg::sum_type   add_sum;
   dwms_pkg::ptr_type   head_next;
   dwms_pkg::cnt_type   count_dec;

   assign clearing          = (state_ff == ST_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_score    = best_out_ff;
   assign rsp_window_sum    = sum_out_ff;
   assign rsp_window_length = len_out_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ev_val    = dwms_pkg::sum_type'(ring_rd_ff);
   assign add_sum   = sum_ff + dwms_pkg::sum_type'(cur_ff.value);
   assign head_next = dwms_pkg::ptr_inc(head_ff);
   assign count_dec = count_ff - dwms_pkg::cnt_type'(1);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      best_out_in  = best_out_ff;
      sum_out_in   = sum_out_ff;
      len_out_in   = len_out_ff;
      q_pop        = 1'b0;
      mark_we      = 1'b0;
      mark_wa      = '0;
      mark_wd      = 1'b0;
      mark_re      = 1'b0;
      mark_ra      = '0;
      ring_we      = 1'b0;
      ring_wa      = '0;
      ring_wd      = '0;
      ring_re      = 1'b0;
      ring_ra      = '0;

      case (state_ff)
         ST_CLEAR: begin
            mark_we = 1'b1;
            mark_wa = clr_ff;
            clr_in  = clr_ff + dwms_pkg::ptr_type'(1);
            if (clr_ff == dwms_pkg::ptr_type'(dwms_pkg::DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (q_item.first) begin
                  state_in = ST_DRAIN_RD;
               end else if (!q_item.in_range) begin
                  state_in = ST_RESULT;
               end else begin
                  mark_re  = 1'b1;
                  mark_ra  = dwms_pkg::value_index(q_item.value);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DRAIN_RD: begin
            if (count_ff == '0) begin
               head_in = '0;
               tail_in = '0;
               sum_in  = '0;
               best_in = '0;
               if (!cur_ff.in_range) begin
                  state_in = ST_RESULT;
               end else begin
                  mark_re  = 1'b1;
                  mark_ra  = dwms_pkg::value_index(cur_ff.value);
                  state_in = ST_CHECK;
               end
            end else begin
               ring_re  = 1'b1;
               ring_ra  = head_ff;
               state_in = ST_DRAIN_WR;
            end
         end
         ST_DRAIN_WR: begin
            mark_we  = 1'b1;
            mark_wa  = dwms_pkg::value_index(ring_rd_ff);
            head_in  = head_next;
            count_in = count_dec;
            state_in = ST_DRAIN_RD;
         end
         ST_CHECK: begin
            if (mark_rd_ff && (count_ff != '0)) begin
               ring_re  = 1'b1;
               ring_ra  = head_ff;
               state_in = ST_EVICT;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_EVICT: begin
            // drop the front value; stop once the duplicate itself leaves or the window empties
            mark_we  = 1'b1;
            mark_wa  = dwms_pkg::value_index(ring_rd_ff);
            sum_in   = (sum_ff >= ev_val) ? (sum_ff - ev_val) : '0;
            head_in  = head_next;
            count_in = count_dec;
            if ((ring_rd_ff == cur_ff.value) || (count_dec == '0)) begin
               state_in = ST_APPEND;
            end else begin
               ring_re = 1'b1;
               ring_ra = head_next;
            end
         end
         ST_APPEND: begin
            mark_we  = 1'b1;
            mark_wa  = dwms_pkg::value_index(cur_ff.value);
            mark_wd  = 1'b1;
            ring_we  = 1'b1;
            ring_wa  = tail_ff;
            ring_wd  = cur_ff.value;
            tail_in  = dwms_pkg::ptr_inc(tail_ff);
            count_in = count_ff + dwms_pkg::cnt_type'(1);
            sum_in   = add_sum;
            if (add_sum > best_ff) begin
               best_in = add_sum;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               best_out_in  = dwms_pkg::score_type'(best_ff);
               sum_out_in   = dwms_pkg::score_type'(sum_ff);
               len_out_in   = dwms_pkg::len_type'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      best_out_ff <= best_out_in;
      sum_out_ff  <= sum_out_in;
      len_out_ff  <= len_out_in;
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (mark_re) begin
         mark_rd_ff <= mark_mem[mark_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_wa] <= ring_wd;
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[ring_ra];
      end
   end

`ifndef ASSERT_OFF
   logic [dwms_pkg::PTR_W:0] ring_end;
   logic [dwms_pkg::PTR_W:0] ring_end_wrap;

   assign ring_end      = {1'b0, head_ff} + {1'b0, count_ff};
   assign ring_end_wrap = (int'(ring_end) >= dwms_pkg::DEPTH) ?
                          (ring_end - (dwms_pkg::PTR_W+1)'(dwms_pkg::DEPTH)) : ring_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= dwms_pkg::MAX_VALUE)
      else $error("window length exceeds the number of distinct values");

   a_ring_span: assert property (@(posedge clock) disable iff (reset)
      ring_end_wrap[dwms_pkg::PTR_W-1:0] == tail_ff)
      else $error("head, length and tail of the window ring disagree");

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT) |-> (count_ff != '0))
      else $error("eviction from an empty window");

   a_best_covers_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) |-> (best_ff >= sum_ff))
      else $error("best score below the current window sum");
`endif

endmodule

// ===== hdl/distinct_window_max_sum_unit.sv =====
// ----------------------------------------------------------------------------
// Distinct-window max sum unit
// Streaming maximum sum over windows of distinct values, one result word per
// request word.
// ----------------------------------------------------------------------------
// Each request word carries one value (1..1023) and a first flag. The unit
// keeps a window of consecutive distinct values: a repeated value evicts the
// window's oldest values until its earlier copy is gone, then joins the back.
// Every request word yields one response word with the best window sum of the
// current array, the current window sum and the window length; a value of zero
// or above the maximum leaves the window alone and just reports. A set first
// flag empties the window and zeroes both sums before the value is handled.
// Steps: an ordinary word passes mark lookup, check, append and result in the
// back end, plus one eviction step per evicted value; an out-of-range value
// goes from pick-up straight to result; a first flag adds a read and a write
// step per value drained from the old window and one final drain step. These
// steps come from the single-port mark table and window ring with registered
// reads; the front stage and a two-word queue absorb stalls on either side.
// After reset it sweeps 1024 mark entries, one a cycle, req_ready held low.
// ----------------------------------------------------------------------------
module distinct_window_max_sum_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dwms_pkg::val_type    req_value,
   input  logic                 req_first,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dwms_pkg::score_type  rsp_best_score,
   output dwms_pkg::score_type  rsp_window_sum,
   output dwms_pkg::len_type    rsp_window_length
);

   logic               clearing;
   logic               push_valid;
   dwms_pkg::item_type push_item;
   logic               push_ready;
   logic               q_valid;
   dwms_pkg::item_type q_item;
   logic               q_pop;

   // Front: take request words and tag them with their range check
   dwms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_first  (req_first),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Queue: let the front keep accepting while the back end evicts
   dwms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (q_pop)
   );

   // Back end: window bookkeeping and the response register
   dwms_back u_back (
      .clock             (clock),
      .reset             (reset),
      .clearing          (clearing),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_score    (rsp_best_score),
      .rsp_window_sum    (rsp_window_sum),
      .rsp_window_length (rsp_window_length)
   );

endmodule

// ===== verif/tb_distinct_window_max_sum_unit.sv =====
// ----------------------------------------------------------------------------
// Distinct-window max sum unit: self-checking testbench
// Sends value/first request words with random gaps and checks every response
// word against a directed expected value or an in-bench model of the
// distinct-value window. A short table of directed words comes first, then
// random arrays: small value pools that repeat often, wide distinct runs, long
// ascending runs, and noise with zero values and stray first flags.
// ----------------------------------------------------------------------------
module tb_distinct_window_max_sum_unit;

   // Clock cycles without any handshake before the run is declared hung; covers the
   // mark table sweep after reset and the drain of a full window.
   localparam int STALL_LIMIT     = 20000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 50;
   // Request words in the whole run, directed table included
   localparam int ITEM_COUNT      = 550;

   typedef struct packed {
      dwms_pkg::score_type best;
      dwms_pkg::score_type sum;
      dwms_pkg::len_type   len;
   } window_report_type;

   typedef struct packed {
      dwms_pkg::val_type  value;
      logic               first;
      logic               typed;
      window_report_type  report;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   dwms_pkg::val_type   req_value;
   logic                req_first;
   logic                rsp_valid;
   logic                rsp_ready;
   dwms_pkg::score_type rsp_best_score;
   dwms_pkg::score_type rsp_window_sum;
   dwms_pkg::len_type   rsp_window_length;

   distinct_window_max_sum_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_score    (rsp_best_score),
      .rsp_window_sum    (rsp_window_sum),
      .rsp_window_length (rsp_window_length)
   );

   // Window model state: presence marks, value ring, pointers and sums
   bit                window_marks [dwms_pkg::DEPTH];
   dwms_pkg::val_type window_ring  [dwms_pkg::DEPTH];
   int                ring_head;
   int                ring_tail;
   int                window_fill;
   longint            running_total;
   longint            best_total;

   window_report_type pending_reports [$];
   directed_row_type  directed_rows [$];
   window_report_type no_report;

   int mismatch_count;
   int stall_cycles;
   int items_sent;

   // Shared pacing controls: no_idle removes gaps on both sides, and
   // hold_off_request makes the receiver stall for a long stretch once.
   bit no_idle;
   bit hold_off_request;

   window_report_type seen_report;
   window_report_type want_report;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Empty the window and zero both sums
   function automatic void clear_window_model();
      for (int i = 0; i < dwms_pkg::DEPTH; i++) begin
         window_marks[i] = 1'b0;
      end
      ring_head     = 0;
      ring_tail     = 0;
      window_fill   = 0;
      running_total = 0;
      best_total    = 0;
   endfunction

   // Apply one request word to the model and return the response it causes
   function automatic window_report_type advance_window(dwms_pkg::val_type v, logic f);
      window_report_type r;
      dwms_pkg::val_type old_v;
      if (f) begin
         clear_window_model();
      end
      if (v != '0 && int'(v) <= dwms_pkg::MAX_VALUE) begin
         // Drop values from the front until the earlier copy is gone
         while (window_marks[v] && window_fill > 0) begin
            old_v = window_ring[ring_head];
            window_marks[old_v] = 1'b0;
            running_total -= (running_total >= old_v) ? longint'(old_v) : running_total;
            ring_head = (ring_head + 1) % dwms_pkg::DEPTH;
            window_fill--;
         end
         window_marks[v] = 1'b1;
         window_ring[ring_tail] = v;
         ring_tail = (ring_tail + 1) % dwms_pkg::DEPTH;
         window_fill++;
         running_total += v;
         if (running_total > best_total) begin
            best_total = running_total;
         end
      end
      r.best = dwms_pkg::score_type'(best_total);
      r.sum  = dwms_pkg::score_type'(running_total);
      r.len  = dwms_pkg::len_type'(window_fill);
      return r;
   endfunction

   task automatic add_row(dwms_pkg::val_type v, logic f, logic typed,
                          int best, int sum, int len);
      directed_row_type row;
      row.value       = v;
      row.first       = f;
      row.typed       = typed;
      row.report.best = dwms_pkg::score_type'(best);
      row.report.sum  = dwms_pkg::score_type'(sum);
      row.report.len  = dwms_pkg::len_type'(len);
      directed_rows.push_back(row);
   endtask

   // Offer one request word after a random gap, hold it until accepted, then
   // record the response it must produce. Valid stays high afterwards so
   // that a zero gap on the next word keeps the channel busy.
   task automatic send_word(dwms_pkg::val_type v, logic f, logic typed,
                            window_report_type typed_report);
      int                gap;
      window_report_type r;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_first <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = advance_window(v, f);
      pending_reports.push_back(typed ? typed_report : r);
      items_sent++;
   endtask

   function automatic void check_field(string name, int want, int seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         mismatch_count++;
      end
   endfunction

   // Response monitor and hang watchdog; sample pre-edge values of the ports
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_report.best = rsp_best_score;
            seen_report.sum  = rsp_window_sum;
            seen_report.len  = rsp_window_length;
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected response word, actual best %0d sum %0d len %0d",
                        $time, seen_report.best, seen_report.sum, seen_report.len);
               mismatch_count++;
            end else begin
               want_report = pending_reports.pop_front();
               check_field("best_score", int'(want_report.best), int'(seen_report.best));
               check_field("window_sum", int'(want_report.sum), int'(seen_report.sum));
               check_field("window_length", int'(want_report.len), int'(seen_report.len));
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Receiver: draw a stall per word, or take the long hold-off when asked
   initial begin : receive_side
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int                kind;
      int                seg_len;
      int                pool;
      int                base;
      int                segment;
      dwms_pkg::val_type v;
      logic              f;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_value        = '0;
      req_first        = 1'b0;
      no_idle          = 1'b0;
      hold_off_request = 1'b0;
      no_report        = '0;
      mismatch_count   = 0;
      stall_cycles     = 0;
      items_sent       = 0;
      clear_window_model();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words: value, first, typed, best, sum, length
      add_row(10'd0,    1'b0, 1'b1, 0,    0,    0);    // zero value right after reset
      add_row(10'd1023, 1'b0, 1'b1, 1023, 1023, 1);    // top value
      add_row(10'd1023, 1'b0, 1'b1, 1023, 1023, 1);    // repeat evicts the only entry
      add_row(10'd1,    1'b1, 1'b1, 1,    1,    1);    // new array, bottom value
      add_row(10'd2,    1'b0, 1'b0, 0,    0,    0);
      add_row(10'd3,    1'b0, 1'b0, 0,    0,    0);
      add_row(10'd2,    1'b0, 1'b0, 0,    0,    0);    // repeat in the middle
      add_row(10'd0,    1'b0, 1'b1, 6,    5,    2);    // ignored value just reports
      add_row(10'd0,    1'b1, 1'b1, 0,    0,    0);    // first with ignored value clears
      add_row(10'd512,  1'b0, 1'b0, 0,    0,    0);
      add_row(10'd511,  1'b0, 1'b0, 0,    0,    0);
      add_row(10'd1,    1'b0, 1'b0, 0,    0,    0);
      add_row(10'd512,  1'b0, 1'b0, 0,    0,    0);    // repeat of the front value
      add_row(10'd1,    1'b0, 1'b0, 0,    0,    0);
      add_row(10'd1023, 1'b1, 1'b1, 1023, 1023, 1);
      add_row(10'd1022, 1'b0, 1'b0, 0,    0,    0);
      add_row(10'h155,  1'b0, 1'b0, 0,    0,    0);
      add_row(10'h2AA,  1'b0, 1'b0, 0,    0,    0);
      add_row(10'h155,  1'b0, 1'b0, 0,    0,    0);
      add_row(10'd1023, 1'b0, 1'b0, 0,    0,    0);
      add_row(10'h3FE,  1'b1, 1'b0, 0,    0,    0);
      add_row(10'h001,  1'b0, 1'b0, 0,    0,    0);
      add_row(10'h3FE,  1'b0, 1'b0, 0,    0,    0);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].value, directed_rows[i].first,
                   directed_rows[i].typed, directed_rows[i].report);
      end

      // Random arrays, one segment at a time
      segment = 0;
      while (items_sent < ITEM_COUNT) begin
         kind = $urandom_range(0, 9);
         // Alternate stretches with no gaps at all
         no_idle = ($urandom_range(0, 5) == 0);
         // Stall the receiver for a long stretch while words keep coming
         if (segment == 2 || $urandom_range(0, 19) == 0) begin
            no_idle          = 1'b1;
            hold_off_request = 1'b1;
         end
         // Pause the sender until every response is back
         if (segment == 4 || $urandom_range(0, 14) == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_reports.size() != 0) @(posedge clock);
         end

         if (kind <= 5 || kind == 9) begin
            // Small pool: frequent repeats, short windows
            pool    = $urandom_range(2, 30);
            base    = $urandom_range(1, 1024 - pool);
            seg_len = $urandom_range(1, 40);
            for (int k = 0; k < seg_len && items_sent < ITEM_COUNT; k++) begin
               v = dwms_pkg::val_type'(base + $urandom_range(0, pool - 1));
               f = (k == 0 && kind != 9);
               send_word(v, f, 1'b0, no_report);
            end
         end else if (kind == 6) begin
            // Wide values: mostly distinct, windows grow long
            seg_len = $urandom_range(10, 60);
            for (int k = 0; k < seg_len && items_sent < ITEM_COUNT; k++) begin
               v = dwms_pkg::val_type'($urandom_range(1, 1023));
               send_word(v, (k == 0), 1'b0, no_report);
            end
         end else if (kind == 7) begin
            // Noise: zero values and stray first flags
            seg_len = $urandom_range(5, 20);
            for (int k = 0; k < seg_len && items_sent < ITEM_COUNT; k++) begin
               v = ($urandom_range(0, 3) == 0) ? dwms_pkg::val_type'(0)
                                               : dwms_pkg::val_type'($urandom_range(0, 1023));
               f = ($urandom_range(0, 7) == 0);
               send_word(v, f, 1'b0, no_report);
            end
         end else begin
            // Long ascending run, then one repeat that evicts the run up to its copy
            seg_len = $urandom_range(100, 250);
            base    = $urandom_range(1, 1024 - seg_len);
            for (int k = 0; k < seg_len && items_sent < ITEM_COUNT; k++) begin
               send_word(dwms_pkg::val_type'(base + k), (k == 0), 1'b0, no_report);
            end
            if (items_sent < ITEM_COUNT) begin
               v = dwms_pkg::val_type'(base + $urandom_range(0, seg_len - 1));
               send_word(v, 1'b0, 1'b0, no_report);
            end
         end
         segment++;
      end

      no_idle = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
